FILE: hdl/gsls_pkg.sv
// Shared types and constants for the Gauss-Seidel solver.
// No dependencies; imported by the top level, gsls_cell, gsls_div and gsls_checker.
package gsls_pkg;

  localparam int MAX_UNKNOWNS = 16;
  localparam int IDX_W        = 4;
  localparam int SIZE_W       = 5;
  localparam int ITER_W       = 8;
  localparam int VALUE_W      = 32;
  localparam int ACC_W        = 64;
  localparam int COEF_DEPTH   = MAX_UNKNOWNS * MAX_UNKNOWNS;
  localparam int COEF_AW      = 2 * IDX_W;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_RHS   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_ITER = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd30;

  // Control shared by every cell of the solution ring.
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hdl/gauss_seidel_linear_solver.sv
// Top level of the Gauss-Seidel solver: sequencer, MAC pipeline, ring of
// solution cells. Depends on gsls_pkg, gsls_ram, gsls_cell, gsls_div.
//
// Load transfers (coefficient or right-hand entry) are taken while idle. A
// start transfer clears x and runs iteration_count sweeps; each row i has a
// setup state, reads MAX_UNKNOWNS coefficients (one coefficient RAM read and
// one ring shift per cycle), drains the pipeline and then divides in the
// bit-serial divider (skipped on a zero diagonal, which sets status); the n
// results are delivered after the last sweep.
// The input side is held off from a start until the last result is loaded
// into the output register; no other stream transfer is taken while solving.
// The right-hand and coefficient stores have no reset: load them first.
module gauss_seidel_linear_solver import gsls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[3:0], column[7:4], operand[39:8]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // unknown_index[3:0], solution[35:4], zero[39:36]
  output logic        m_tlast,
  output logic        m_tuser,   // status[0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_MAC, S_DRAIN, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  matrix_size;
  logic [ITER_W-1:0]  iteration_count;
  logic [SIZE_W-1:0]  n_eff;

  logic [IDX_W-1:0]   i_idx;
  logic [IDX_W-1:0]   j_idx;
  logic [ITER_W-1:0]  sweep;
  logic               drain;
  logic               status;

  logic [VALUE_W-1:0] rhs [MAX_UNKNOWNS];

  // MAC pipeline
  logic               vd, dd, pv;
  logic [VALUE_W-1:0] xd;
  logic [ACC_W-1:0]   prod;
  logic [ACC_W-1:0]   num;
  logic [VALUE_W-1:0] diag;
  logic [VALUE_W-1:0] coef_rd;
  logic [ACC_W:0]     diff;
  logic [ACC_W-1:0]   num_sub;

  // ring
  cell_ctrl_t         cctrl;
  logic               cell_wr;
  logic [VALUE_W-1:0] cell_wval;
  logic [VALUE_W-1:0] cell_val [MAX_UNKNOWNS];

  logic               div_start, div_done;
  logic [VALUE_W-1:0] div_quot;

  logic               in_xfer;
  logic               coef_wr;
  logic [COEF_AW-1:0] coef_waddr;
  logic               row_last;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign coef_wr   = in_xfer && (s_tuser == CMD_COEF);
  // row in the upper address bits, column in the lower
  assign coef_waddr = {s_tdata[3:0], s_tdata[7:4]};

  // clamp matrix size into 1..MAX_UNKNOWNS
  always_comb begin
    if (matrix_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(MAX_UNKNOWNS)) begin
      n_eff = SIZE_W'(MAX_UNKNOWNS);
    end else begin
      n_eff = matrix_size;
    end
  end

  assign row_last = ({1'b0, i_idx} == n_eff - SIZE_W'(1));

  gsls_ram #(.WIDTH(VALUE_W), .DEPTH(COEF_DEPTH)) u_coef (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (coef_waddr),
    .wr_data (s_tdata[39:8]),
    .rd_addr ({i_idx, j_idx}),
    .rd_data (coef_rd)
  );

  // saturating subtract of the product from the numerator
  always_comb begin
    diff = {num[ACC_W-1], num} - {prod[ACC_W-1], prod};
    if (diff[ACC_W] != diff[ACC_W-1]) begin
      num_sub = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      num_sub = diff[ACC_W-1:0];
    end
  end

  assign cctrl.clr   = in_xfer && (s_tuser == CMD_START);
  assign cctrl.shift = (state == S_MAC) || ((state == S_OUT) && (!m_tvalid || m_tready));

  genvar k;
  generate
    for (k = 0; k < MAX_UNKNOWNS; k++) begin : g_cell
      gsls_cell u_cell (
        .clk    (clk),
        .ctrl   (cctrl),
        .wr     (cell_wr && (i_idx == IDX_W'(k))),
        .wr_val (cell_wval),
        .nb_val (cell_val[(k + 1) % MAX_UNKNOWNS]),
        .val    (cell_val[k])
      );
    end
  endgenerate

  gsls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (diag),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    div_start = (state == S_DIV) && (diag != '0);
    cell_wr   = ((state == S_DIV) && (diag == '0)) || ((state == S_WAIT) && div_done);
    cell_wval = (state == S_WAIT) ? div_quot : '0;
  end

  // right-hand store and MAC datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && (s_tuser == CMD_RHS)) begin
      rhs[s_tdata[3:0]] <= s_tdata[39:8];
    end
    xd   <= cell_val[0];
    prod <= ACC_W'($signed(coef_rd) * $signed(xd));
    if (dd) begin
      diag <= coef_rd;
    end
    if (state == S_ROW) begin
      num <= {{(ACC_W-VALUE_W-16){rhs[i_idx][VALUE_W-1]}}, rhs[i_idx], 16'd0};
    end else if (pv) begin
      num <= num_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      matrix_size     <= SIZE_RESET;
      iteration_count <= ITER_RESET;
      i_idx           <= '0;
      j_idx           <= '0;
      sweep           <= '0;
      drain           <= 1'b0;
      status          <= 1'b0;
      vd              <= 1'b0;
      dd              <= 1'b0;
      pv              <= 1'b0;
      m_tvalid        <= 1'b0;
      m_tlast         <= 1'b0;
      m_tuser         <= 1'b0;
      m_tdata         <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SIZE: matrix_size     <= cfg_data[SIZE_W-1:0];
          REG_ITER: iteration_count <= cfg_data;
          default: ;
        endcase
      end
      // load the output register in S_OUT, drop it once taken
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // flag column j's product for accumulation; skip the diagonal and columns beyond n
      vd <= (state == S_MAC) && (j_idx != i_idx) && ({1'b0, j_idx} < n_eff);
      dd <= (state == S_MAC) && (j_idx == i_idx);
      pv <= vd;
      unique case (state) inside
        S_IDLE: begin
          if (in_xfer && (s_tuser == CMD_START)) begin
            status <= 1'b0;
            i_idx  <= '0;
            sweep  <= '0;
            state  <= (iteration_count == '0) ? S_OUT : S_ROW;
          end
        end
        S_ROW: begin
          j_idx <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          j_idx <= j_idx + 1'b1;
          if (j_idx == IDX_W'(MAX_UNKNOWNS - 1)) begin
            drain <= 1'b0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_DIV;
          end
        end
        S_DIV, S_WAIT: begin
          if ((state == S_DIV) && (diag != '0)) begin
            state <= S_WAIT;
          end else if (cell_wr) begin
            if (state == S_DIV) begin
              status <= 1'b1;
            end
            if (row_last) begin
              i_idx <= '0;
              if (sweep == iteration_count - 1'b1) begin
                state <= S_OUT;
              end else begin
                sweep <= sweep + 1'b1;
                state <= S_ROW;
              end
            end else begin
              i_idx <= i_idx + 1'b1;
              state <= S_ROW;
            end
          end
        end
        S_OUT: begin
          // load the head cell into the output register, then rotate
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'd0, cell_val[0], i_idx};
            m_tlast  <= row_last;
            m_tuser  <= status;
            i_idx    <= i_idx + 1'b1;
            if (row_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/gsls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hdl/gsls_cell.sv
// One entry of the solution ring: holds x[k], shifts toward the head.
// Depends on gsls_pkg.
module gsls_cell import gsls_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               wr,
  input  logic [VALUE_W-1:0] wr_val,
  input  logic [VALUE_W-1:0] nb_val,
  output logic [VALUE_W-1:0] val
);
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      val <= '0;
    end else if (wr) begin
      val <= wr_val;
    end else if (ctrl.shift) begin
      val <= nb_val;
    end
  end
endmodule

FILE: hdl/gsls_div.sv
// Radix-2 restoring divider: 64-bit signed numerator by 32-bit signed
// divisor, truncated toward zero and clamped to 32 bits. Depends on gsls_pkg.
module gsls_div import gsls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ACC_W-1:0]   num,
  input  logic [VALUE_W-1:0] den,
  output logic               done,
  output logic [VALUE_W-1:0] quot
);
  logic               busy;
  logic [6:0]         cnt;
  logic               neg;
  logic [VALUE_W-1:0] dmag;
  logic [VALUE_W-1:0] rem;
  logic [ACC_W-1:0]   q;
  logic [VALUE_W:0]   rem_sh;
  logic [VALUE_W+1:0] trial;
  logic [ACC_W-1:0]   q_next;
  logic [VALUE_W-1:0] rem_next;

  localparam logic [ACC_W-1:0] POS_MAX = ACC_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
  localparam logic [ACC_W-1:0] NEG_MAG = ACC_W'(64'd1 << (VALUE_W - 1));

  always_comb begin
    rem_sh   = {rem, q[ACC_W-1]};
    trial    = {1'b0, rem_sh} - {2'b00, dmag};
    q_next   = {q[ACC_W-2:0], ~trial[VALUE_W+1]};
    rem_next = trial[VALUE_W+1] ? rem_sh[VALUE_W-1:0] : trial[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[ACC_W-1] ^ den[VALUE_W-1];
        q    <= num[ACC_W-1] ? (~num + 1'b1) : num;
        dmag <= den[VALUE_W-1] ? (~den + 1'b1) : den;
        rem  <= '0;
      end else if (busy) begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt + 7'd1;
        if (cnt == 7'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          // clamp the signed quotient to the value range
          if (neg) begin
            quot <= (q_next > NEG_MAG) ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : (~q_next[VALUE_W-1:0] + 1'b1);
          end else begin
            quot <= (q_next > POS_MAX) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                       : q_next[VALUE_W-1:0];
          end
        end
      end
    end
  end
endmodule

FILE: hdl/gsls_checker.sv
// Port-level checks for the Gauss-Seidel solver, bound to the top level.
// Depends on gsls_pkg and gauss_seidel_linear_solver.
module gsls_checker import gsls_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the block");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_START) |=> !s_tready)
    else $error("input taken right after a start");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:36] == 4'd0))
    else $error("result padding not zero");
endmodule

bind gauss_seidel_linear_solver gsls_checker u_gsls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
